// ===== src/rcfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rcfp_pkg;

  localparam logic [7:0] HDR_BYTE    = 8'h79;
  localparam logic [7:0] KIND_BUTTON = 8'h62;
  localparam logic [7:0] KIND_SLIDER = 8'h76;
  localparam logic [7:0] KIND_JOY    = 8'h64;
  localparam logic [7:0] TERM_LF     = 8'h0A;
  localparam logic [7:0] TERM_CR     = 8'h0D;

  localparam logic [1:0] FT_BUTTON   = 2'd0;
  localparam logic [1:0] FT_SLIDER   = 2'd1;
  localparam logic [1:0] FT_JOY      = 2'd2;

  localparam logic [8:0] JOY_RESET   = 9'd510;

endpackage

`default_nettype wire

// ===== src/remote_command_frame_parser_core.sv =====
// A completing rx_byte beat passes the input register, then the frame result register.
// Throughput: one byte beat per cycle; the input register and the result
// register are each one beat deep, with byte_stall raised only while a
// registered byte waits behind a stalled result.
// Reset (rst, synchronous, active high): byte position, frame type, stored
// bytes and held button/slider values clear to 0, held joystick value to 510.
`timescale 1ns / 1ps
`default_nettype none

module remote_command_frame_parser_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_stall,
  input  wire logic [7:0] rx_byte,
  output logic            frame_valid,
  input  wire logic       frame_stall,
  output logic [1:0]      frame_kind,
  output logic [8:0]      frame_value,
  output logic [7:0]      button_value,
  output logic [7:0]      slider_value,
  output logic [8:0]      joystick_value
);

  localparam logic [2:0] POS_HDR  = 3'd0;
  localparam logic [2:0] POS_KIND = 3'd1;
  localparam logic [2:0] POS_VA   = 3'd2;
  localparam logic [2:0] POS_VB   = 3'd3;
  localparam logic [2:0] POS_TAIL = 3'd4;
  localparam logic [2:0] POS_END  = 3'd5;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       out_free;
  logic       step;

  logic [2:0] pos,           pos_next;
  logic [1:0] ftype,         ftype_next;
  logic [7:0] byte_a,        byte_a_next;
  logic [7:0] byte_b,        byte_b_next;
  logic [7:0] tail,          tail_next;
  logic [7:0] held_button,   held_button_next;
  logic [7:0] held_slider,   held_slider_next;
  logic [8:0] held_joy,      held_joy_next;
  logic       emit;
  logic [1:0] emit_kind;
  logic [8:0] emit_value;
  logic [8:0] joy_sum;

  assign out_free   = !frame_valid || !frame_stall;
  assign byte_stall = in_vld && !out_free;
  assign step       = in_vld && out_free;
  assign joy_sum    = {1'b0, byte_a} + {1'b0, byte_b};

  always_comb begin
    pos_next         = pos;
    ftype_next       = ftype;
    byte_a_next      = byte_a;
    byte_b_next      = byte_b;
    tail_next        = tail;
    held_button_next = held_button;
    held_slider_next = held_slider;
    held_joy_next    = held_joy;
    emit             = 1'b0;
    emit_kind        = ftype;
    emit_value       = {1'b0, byte_a};
    unique case (pos)
      POS_HDR: begin
        if (in_byte == rcfp_pkg::HDR_BYTE) pos_next = POS_KIND;
      end
      POS_KIND: begin
        unique case (in_byte)
          rcfp_pkg::KIND_BUTTON: begin
            ftype_next = rcfp_pkg::FT_BUTTON;
            pos_next   = POS_VA;
          end
          rcfp_pkg::KIND_SLIDER: begin
            ftype_next = rcfp_pkg::FT_SLIDER;
            pos_next   = POS_VA;
          end
          rcfp_pkg::KIND_JOY: begin
            ftype_next = rcfp_pkg::FT_JOY;
            pos_next   = POS_VA;
          end
          default: ;
        endcase
      end
      POS_VA: begin
        byte_a_next = in_byte;
        pos_next    = POS_VB;
      end
      POS_VB: begin
        byte_b_next = in_byte;
        pos_next    = POS_TAIL;
      end
      POS_TAIL: begin
        tail_next = in_byte;
        if (ftype == rcfp_pkg::FT_BUTTON || ftype == rcfp_pkg::FT_SLIDER) begin
          if (byte_b == rcfp_pkg::TERM_LF && in_byte == rcfp_pkg::TERM_CR) begin
            pos_next = POS_HDR;
            emit     = 1'b1;
            if (ftype == rcfp_pkg::FT_BUTTON) held_button_next = byte_a;
            else held_slider_next = byte_a;
          end
        end else if (ftype == rcfp_pkg::FT_JOY) begin
          pos_next = POS_END;
        end
      end
      POS_END: begin
        if (tail == rcfp_pkg::TERM_LF && in_byte == rcfp_pkg::TERM_CR) begin
          pos_next      = POS_HDR;
          held_joy_next = joy_sum;
          emit          = 1'b1;
          emit_kind     = rcfp_pkg::FT_JOY;
          emit_value    = joy_sum;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!byte_stall) begin
      in_vld <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall) in_byte <= rx_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= POS_HDR;
      ftype       <= rcfp_pkg::FT_BUTTON;
      byte_a      <= '0;
      byte_b      <= '0;
      tail        <= '0;
      held_button <= '0;
      held_slider <= '0;
      held_joy    <= rcfp_pkg::JOY_RESET;
    end else if (step) begin
      pos         <= pos_next;
      ftype       <= ftype_next;
      byte_a      <= byte_a_next;
      byte_b      <= byte_b_next;
      tail        <= tail_next;
      held_button <= held_button_next;
      held_slider <= held_slider_next;
      held_joy    <= held_joy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (out_free) begin
      frame_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      frame_kind     <= emit_kind;
      frame_value    <= emit_value;
      button_value   <= held_button_next;
      slider_value   <= held_slider_next;
      joystick_value <= held_joy_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/rcfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rcfp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       frame_valid,
  input wire logic       frame_stall,
  input wire logic [1:0] frame_kind,
  input wire logic [8:0] frame_value,
  input wire logic [7:0] button_value,
  input wire logic [7:0] slider_value,
  input wire logic [8:0] joystick_value
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_stall |=> frame_valid && $stable(frame_kind)
      && $stable(frame_value) && $stable(joystick_value))
    else $error("stalled frame beat changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> frame_kind == rcfp_pkg::FT_BUTTON || frame_kind == rcfp_pkg::FT_SLIDER
      || frame_kind == rcfp_pkg::FT_JOY)
    else $error("frame kind out of range");

  a_button: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_kind == rcfp_pkg::FT_BUTTON |-> frame_value == {1'b0, button_value})
    else $error("button value not held");

  a_slider: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_kind == rcfp_pkg::FT_SLIDER |-> frame_value == {1'b0, slider_value})
    else $error("slider value not held");

  a_joy: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_kind == rcfp_pkg::FT_JOY |-> frame_value == joystick_value)
    else $error("joystick value not held");

endmodule

bind remote_command_frame_parser_core rcfp_checker u_rcfp_checker (.*);

`default_nettype wire

// ===== tb/remote_command_frame_parser_core_tb.sv =====
`timescale 1ns / 1ps

module remote_command_frame_parser_core_tb;

  localparam logic [2:0] AT_HEADER  = 3'd0;
  localparam logic [2:0] AT_KIND    = 3'd1;
  localparam logic [2:0] AT_VALUE_A = 3'd2;
  localparam logic [2:0] AT_VALUE_B = 3'd3;
  localparam logic [2:0] AT_TAIL    = 3'd4;
  localparam logic [2:0] AT_CR      = 3'd5;

  localparam int LIVE_BYTES = 1450;
  localparam int DIR_ROWS   = 25;

  typedef struct packed {
    logic [1:0] kind;
    logic [8:0] value;
    logic [7:0] button;
    logic [7:0] slider;
    logic [8:0] joystick;
  } frame_report_t;

  typedef struct packed {
    logic [7:0]    data;
    bit            typed;
    frame_report_t rep;
  } dir_row_t;

  logic       clk;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       frame_valid;
  logic       frame_stall = 1'b0;
  logic [1:0] frame_kind;
  logic [8:0] frame_value;
  logic [7:0] button_value;
  logic [7:0] slider_value;
  logic [8:0] joystick_value;

  remote_command_frame_parser_core u_top (
    .clk            (clk),
    .rst            (rst),
    .byte_valid     (byte_valid),
    .byte_stall     (byte_stall),
    .rx_byte        (rx_byte),
    .frame_valid    (frame_valid),
    .frame_stall    (frame_stall),
    .frame_kind     (frame_kind),
    .frame_value    (frame_value),
    .button_value   (button_value),
    .slider_value   (slider_value),
    .joystick_value (joystick_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [2:0] par_pos   = AT_HEADER;
  logic [1:0] par_kind  = rcfp_pkg::FT_BUTTON;
  logic [7:0] par_a     = 8'h00;
  logic [7:0] par_b     = 8'h00;
  logic [7:0] par_tail  = 8'h00;
  logic [7:0] held_btn  = 8'h00;
  logic [7:0] held_sld  = 8'h00;
  logic [8:0] held_joy  = rcfp_pkg::JOY_RESET;

  frame_report_t pending_frames [$];
  frame_report_t head_rep;
  int            errors = 0;

  task automatic parse_byte(input logic [7:0] b, output bit done, output frame_report_t rep);
    done = 1'b0;
    rep  = '0;
    case (par_pos)
      AT_HEADER: if (b == rcfp_pkg::HDR_BYTE) par_pos = AT_KIND;
      AT_KIND: begin
        if (b == rcfp_pkg::KIND_BUTTON) begin
          par_kind = rcfp_pkg::FT_BUTTON;
          par_pos  = AT_VALUE_A;
        end else if (b == rcfp_pkg::KIND_SLIDER) begin
          par_kind = rcfp_pkg::FT_SLIDER;
          par_pos  = AT_VALUE_A;
        end else if (b == rcfp_pkg::KIND_JOY) begin
          par_kind = rcfp_pkg::FT_JOY;
          par_pos  = AT_VALUE_A;
        end
      end
      AT_VALUE_A: begin
        par_a   = b;
        par_pos = AT_VALUE_B;
      end
      AT_VALUE_B: begin
        par_b   = b;
        par_pos = AT_TAIL;
      end
      AT_TAIL: begin
        par_tail = b;
        if (par_kind == rcfp_pkg::FT_BUTTON || par_kind == rcfp_pkg::FT_SLIDER) begin
          if (par_b == rcfp_pkg::TERM_LF && par_tail == rcfp_pkg::TERM_CR) begin
            par_pos = AT_HEADER;
            if (par_kind == rcfp_pkg::FT_BUTTON) held_btn = par_a;
            else held_sld = par_a;
            done = 1'b1;
            rep  = '{par_kind, {1'b0, par_a}, held_btn, held_sld, held_joy};
          end
        end else if (par_kind == rcfp_pkg::FT_JOY) begin
          par_pos = AT_CR;
        end
      end
      AT_CR: begin
        if (par_tail == rcfp_pkg::TERM_LF && b == rcfp_pkg::TERM_CR) begin
          par_pos  = AT_HEADER;
          held_joy = {1'b0, par_a} + {1'b0, par_b};
          done     = 1'b1;
          rep      = '{rcfp_pkg::FT_JOY, held_joy, held_btn, held_sld, held_joy};
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, output bit done, output frame_report_t rep);
    @(negedge clk);
    byte_valid <= 1'b1;
    rx_byte    <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    parse_byte(b, done, rep);
  endtask

  task automatic push_byte(input logic [7:0] b);
    bit            done;
    frame_report_t rep;
    send_byte(b, done, rep);
    if (done) pending_frames.push_back(rep);
  endtask

  task automatic idle_sender(input int n);
    @(negedge clk);
    byte_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  function automatic logic [7:0] value_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return 8'h00;
    if (r < 30) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [7:0] not_lf();
    logic [7:0] b;
    b = 8'($urandom);
    while (b == rcfp_pkg::TERM_LF) b = 8'($urandom);
    return b;
  endfunction

  // keep the parser on paths that can still complete; break frames only where it recovers
  task automatic pick_byte(output logic [7:0] b, output bit live);
    int unsigned r;
    r    = $urandom_range(99);
    live = 1'b1;
    case (par_pos)
      AT_HEADER: begin
        b = (r < 85) ? rcfp_pkg::HDR_BYTE : 8'($urandom);
        live = (b == rcfp_pkg::HDR_BYTE);
      end
      AT_KIND: begin
        if (r < 30) b = rcfp_pkg::KIND_BUTTON;
        else if (r < 58) b = rcfp_pkg::KIND_SLIDER;
        else if (r < 86) b = rcfp_pkg::KIND_JOY;
        else b = 8'($urandom);
        live = (b == rcfp_pkg::KIND_BUTTON || b == rcfp_pkg::KIND_SLIDER
                || b == rcfp_pkg::KIND_JOY);
      end
      AT_VALUE_A: b = value_byte();
      AT_VALUE_B: b = (par_kind == rcfp_pkg::FT_JOY) ? value_byte() : rcfp_pkg::TERM_LF;
      AT_TAIL:    b = (par_kind == rcfp_pkg::FT_JOY || r < 80) ?
                      ((par_kind == rcfp_pkg::FT_JOY) ? rcfp_pkg::TERM_LF : rcfp_pkg::TERM_CR)
                      : 8'($urandom);
      default:    b = (r < 80) ? rcfp_pkg::TERM_CR : 8'($urandom);
    endcase
  endtask

  function automatic dir_row_t raw_row(input logic [7:0] b);
    return '{b, 1'b0, frame_report_t'(0)};
  endfunction

  function automatic dir_row_t end_row(input logic [7:0] b, input logic [1:0] k,
                                       input logic [8:0] v, input logic [7:0] bt,
                                       input logic [7:0] sl, input logic [8:0] jy);
    return '{b, 1'b1, frame_report_t'({k, v, bt, sl, jy})};
  endfunction

  dir_row_t dir_rows [DIR_ROWS];

  initial begin
    int            i;
    int            live_cnt;
    int            burst_left;
    bit            drained;
    bit            done;
    bit            live;
    logic [7:0]    b;
    logic [1:0]    k;
    frame_report_t rep;

    dir_rows = '{
      raw_row(rcfp_pkg::HDR_BYTE), raw_row(rcfp_pkg::KIND_BUTTON), raw_row(8'hFF),
      raw_row(rcfp_pkg::TERM_LF),
      end_row(rcfp_pkg::TERM_CR, rcfp_pkg::FT_BUTTON, 9'd255, 8'd255, 8'd0,
              rcfp_pkg::JOY_RESET),
      raw_row(rcfp_pkg::HDR_BYTE), raw_row(8'hAA), raw_row(rcfp_pkg::KIND_SLIDER),
      raw_row(8'h00), raw_row(rcfp_pkg::TERM_LF), raw_row(8'h0C),
      end_row(rcfp_pkg::TERM_CR, rcfp_pkg::FT_SLIDER, 9'd0, 8'd255, 8'd0,
              rcfp_pkg::JOY_RESET),
      raw_row(rcfp_pkg::HDR_BYTE), raw_row(rcfp_pkg::KIND_JOY), raw_row(8'hFF),
      raw_row(8'hFF), raw_row(rcfp_pkg::TERM_LF), raw_row(8'h0B),
      end_row(rcfp_pkg::TERM_CR, rcfp_pkg::FT_JOY, 9'd510, 8'd255, 8'd0, 9'd510),
      raw_row(rcfp_pkg::HDR_BYTE), raw_row(rcfp_pkg::KIND_JOY), raw_row(8'h00),
      raw_row(8'h00), raw_row(rcfp_pkg::TERM_LF),
      end_row(rcfp_pkg::TERM_CR, rcfp_pkg::FT_JOY, 9'd0, 8'd255, 8'd0, 9'd0)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_ROWS; i++) begin
      send_byte(dir_rows[i].data, done, rep);
      if (dir_rows[i].typed) pending_frames.push_back(dir_rows[i].rep);
      else if (done) pending_frames.push_back(rep);
      if ($urandom_range(3) == 0) idle_sender($urandom_range(1, 4));
    end

    live_cnt   = 0;
    burst_left = $urandom_range(1, 20);
    drained    = 1'b0;
    while (live_cnt < LIVE_BYTES || par_pos != AT_HEADER) begin
      pick_byte(b, live);
      push_byte(b);
      if (live) live_cnt++;
      if (!drained && live_cnt >= LIVE_BYTES / 2) begin
        drained = 1'b1;
        idle_sender(1);
        while (pending_frames.size() != 0) @(posedge clk);
      end
      burst_left--;
      if (burst_left <= 0) begin
        idle_sender($urandom_range(1, 8));
        burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      end
    end

    // drive the parser into a frame whose terminator can never match
    push_byte(rcfp_pkg::HDR_BYTE);
    k = 2'($urandom_range(2));
    push_byte((k == rcfp_pkg::FT_BUTTON) ? rcfp_pkg::KIND_BUTTON :
              (k == rcfp_pkg::FT_SLIDER) ? rcfp_pkg::KIND_SLIDER : rcfp_pkg::KIND_JOY);
    push_byte(value_byte());
    if (k == rcfp_pkg::FT_JOY) push_byte(value_byte());
    push_byte(not_lf());
    push_byte(rcfp_pkg::TERM_CR);
    push_byte(rcfp_pkg::TERM_LF);
    push_byte(rcfp_pkg::TERM_CR);
    push_byte(8'($urandom));

    idle_sender(1);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  int unsigned rcv_cyc = 0;

  always @(negedge clk) begin
    rcv_cyc <= rcv_cyc + 1;
    case (rcv_cyc[9:7])
      3'd0, 3'd1: frame_stall <= 1'b0;
      3'd5:       frame_stall <= (rcv_cyc[3:0] < 4'd11);
      3'd6:       frame_stall <= rcv_cyc[0];
      3'd7:       frame_stall <= ($urandom_range(99) < 70);
      default:    frame_stall <= ($urandom_range(99) < 30);
    endcase
  end

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) begin
      if (pending_frames.size() == 0) begin
        $error("frame beat with none pending: kind %0d value %0d", frame_kind, frame_value);
        errors++;
      end else begin
        head_rep = pending_frames.pop_front();
        cmp_field("frame_kind", int'(head_rep.kind), int'(frame_kind));
        cmp_field("frame_value", int'(head_rep.value), int'(frame_value));
        cmp_field("button_value", int'(head_rep.button), int'(button_value));
        cmp_field("slider_value", int'(head_rep.slider), int'(slider_value));
        cmp_field("joystick_value", int'(head_rep.joystick), int'(joystick_value));
      end
    end
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
